### design/dtk_pkg.sv
// Package for the DIS truth kinematics block.
// Holds the request and result types, particle codes and the control structs
// shared by the capture, product and divide/root modules. No dependencies.
`default_nettype none

package dtk_pkg;

	localparam logic [7:0]         STATUS_BEAM   = 8'd4;
	localparam logic [7:0]         STATUS_FINAL  = 8'd1;
	localparam logic signed [31:0] CODE_ELECTRON = 32'sd11;
	localparam logic signed [31:0] CODE_PROTON   = 32'sd2212;
	localparam logic signed [31:0] CODE_NEUTRON  = 32'sd2112;
	localparam logic [30:0]        PM_RESET      = 31'd61491;

	typedef struct packed {
		logic [7:0]         gen_status;
		logic signed [31:0] pdg_code;
		logic signed [31:0] mom_x;
		logic signed [31:0] mom_y;
		logic signed [31:0] mom_z;
		logic signed [31:0] energy;
		logic               last_in_event;
	} req_t;

	typedef struct packed {
		logic signed [47:0] q_squared;
		logic signed [31:0] inelasticity_y;
		logic signed [47:0] energy_transfer_nu;
		logic signed [31:0] bjorken_x;
		logic [31:0]        invariant_mass_w;
		logic               w_invalid;
		logic               divide_fault;
	} res_t;

	// Components in order x, y, z, E.
	typedef logic [3:0][31:0] vec_t;

	typedef struct packed {
		vec_t ebeam;
		vec_t hbeam;
		vec_t scat;
	} event_t;

	typedef logic signed [57:0] mk_t;

	typedef struct packed {
		mk_t qq;
		mk_t qh;
		mk_t eh;
		mk_t ss;
	} mk_res_t;

	typedef enum logic {
		DS_DIV,
		DS_SQRT
	} ds_op_t;

	typedef struct packed {
		logic        go;
		ds_op_t      op;
		logic        frac24;
		logic [63:0] num;
		logic [57:0] den;
	} ds_cmd_t;

endpackage

`default_nettype wire

### design/dtk_select.sv
// Particle capture for the DIS truth kinematics block.
// Keeps beam electron, beam hadron and scattered electron of the current event.
// Depends on dtk_pkg.
`default_nettype none

module dtk_select
	import dtk_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   take,
	input  req_t        req,
	input  wire logic   clear,
	output event_t      ev,
	output logic        compute
);

	event_t ev_q;
	logic   e_found_q, h_found_q, s_found_q;
	logic   hit_e, hit_h, hit_s, open_ev;
	logic   e_n, h_n, s_n, all_n;
	vec_t   v;

	assign v       = {req.energy, req.mom_z, req.mom_y, req.mom_x};
	assign open_ev = !(e_found_q && h_found_q && s_found_q);
	assign hit_e   = open_ev && req.gen_status == STATUS_BEAM && req.pdg_code == CODE_ELECTRON;
	assign hit_h   = open_ev && !hit_e && req.gen_status == STATUS_BEAM &&
		(req.pdg_code == CODE_PROTON || req.pdg_code == CODE_NEUTRON);
	assign hit_s   = open_ev && req.gen_status == STATUS_FINAL &&
		req.pdg_code == CODE_ELECTRON && !s_found_q;
	assign e_n     = e_found_q || hit_e;
	assign h_n     = h_found_q || hit_h;
	assign s_n     = s_found_q || hit_s;
	assign all_n   = e_n && h_n && s_n;
	assign compute = take && req.last_in_event && all_n;
	assign ev      = ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q      <= '0;
			e_found_q <= 1'b0;
			h_found_q <= 1'b0;
			s_found_q <= 1'b0;
		end else if (clear || (take && req.last_in_event && !all_n)) begin
			ev_q      <= '0;
			e_found_q <= 1'b0;
			h_found_q <= 1'b0;
			s_found_q <= 1'b0;
		end else if (take) begin
			if (hit_e) begin
				ev_q.ebeam <= v;
			end
			if (hit_h) begin
				ev_q.hbeam <= v;
			end
			if (hit_s) begin
				ev_q.scat <= v;
			end
			e_found_q <= e_n;
			h_found_q <= h_n;
			s_found_q <= s_n;
		end
	end

endmodule

`default_nettype wire

### design/dtk_mac.sv
// Minkowski product unit for the DIS truth kinematics block.
// One 19x35 multiplier, used twice per component product, builds q.q, q.p, e.p
// and s.s term by term. Depends on dtk_pkg.
`default_nettype none

module dtk_mac
	import dtk_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic go,
	input  event_t    ev,
	output logic      done,
	output mk_res_t   mk
);

	typedef enum logic [2:0] {
		MK_IDLE,
		MK_LO,
		MK_HI,
		MK_ADD,
		MK_ACC
	} mk_state_t;

	mk_state_t          state_q;
	logic [1:0]         prod_q, comp_q;
	logic [53:0]        prod_lo_q, mul_q, term_q;
	logic               neg_q, sub_q, done_q;
	mk_t                sum_q;
	mk_res_t            mk_q;
	logic signed [34:0] e_c, h_c, s_c, q_c, sum_c, a_op, b_op;
	logic [34:0]        ma, mb;
	logic [18:0]        mul_a;
	logic [53:0]        mul_p;
	logic [69:0]        full;
	mk_t                delta, sum_n;

	assign e_c   = 35'(signed'(ev.ebeam[comp_q]));
	assign h_c   = 35'(signed'(ev.hbeam[comp_q]));
	assign q_c   = e_c - 35'(signed'(ev.scat[comp_q]));
	assign s_c   = h_c + q_c;

	always_comb begin
		case (prod_q)
			2'd0:    begin a_op = q_c; b_op = q_c; end
			2'd1:    begin a_op = q_c; b_op = h_c; end
			2'd2:    begin a_op = e_c; b_op = h_c; end
			default: begin a_op = s_c; b_op = s_c; end
		endcase
	end

	assign ma    = a_op[34] ? 35'(-a_op) : 35'(a_op);
	assign mb    = b_op[34] ? 35'(-b_op) : 35'(b_op);
	assign mul_a = (state_q == MK_LO) ? {3'b0, ma[15:0]} : ma[34:16];
	assign mul_p = 54'(mul_a) * 54'(mb);
	assign full  = {16'b0, prod_lo_q} + {mul_q, 16'b0};
	assign delta = (neg_q ^ sub_q) ? -58'(term_q) : 58'(term_q);
	assign sum_n = sum_q + delta;
	assign sum_c = '0;
	assign done  = done_q;
	assign mk    = mk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= MK_IDLE;
			prod_q    <= '0;
			comp_q    <= '0;
			done_q    <= 1'b0;
			sum_q     <= '0;
			mk_q      <= '0;
			prod_lo_q <= '0;
			mul_q     <= '0;
			term_q    <= '0;
			neg_q     <= 1'b0;
			sub_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MK_IDLE: begin
					if (go) begin
						prod_q  <= '0;
						comp_q  <= '0;
						sum_q   <= 58'(sum_c);
						state_q <= MK_LO;
					end
				end
				MK_LO: begin
					mul_q   <= mul_p;
					state_q <= MK_HI;
				end
				MK_HI: begin
					prod_lo_q <= mul_q;
					mul_q     <= mul_p;
					state_q   <= MK_ADD;
				end
				MK_ADD: begin
					term_q  <= full[69:16];
					neg_q   <= a_op[34] ^ b_op[34];
					sub_q   <= (comp_q != 2'd3);
					state_q <= MK_ACC;
				end
				MK_ACC: begin
					if (comp_q == 2'd3) begin
						case (prod_q)
							2'd0:    mk_q.qq <= sum_n;
							2'd1:    mk_q.qh <= sum_n;
							2'd2:    mk_q.eh <= sum_n;
							default: mk_q.ss <= sum_n;
						endcase
						sum_q  <= '0;
						comp_q <= '0;
						if (prod_q == 2'd3) begin
							done_q  <= 1'b1;
							state_q <= MK_IDLE;
						end else begin
							prod_q  <= prod_q + 2'd1;
							state_q <= MK_LO;
						end
					end else begin
						sum_q   <= sum_n;
						comp_q  <= comp_q + 2'd1;
						state_q <= MK_LO;
					end
				end
				default: state_q <= MK_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/dtk_divsqrt.sv
// Shared restoring divide and square root unit for the DIS truth kinematics block.
// One compare and subtract per cycle: one quotient bit or one root bit a step.
// Depends on dtk_pkg.
`default_nettype none

module dtk_divsqrt
	import dtk_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  ds_cmd_t     cmd,
	output logic        done,
	output logic [63:0] quo,
	output logic        ovf
);

	typedef enum logic {
		DS_IDLE,
		DS_RUN
	} ds_state_t;

	ds_state_t   state_q;
	ds_op_t      op_q;
	logic [81:0] x_q;
	logic [59:0] r_q;
	logic [57:0] den_q;
	logic [63:0] q_q;
	logic [6:0]  cnt_q;
	logic        ovf_q, done_q;
	logic [59:0] shifted, trial;
	logic        ge;

	assign shifted = (op_q == DS_DIV) ? {r_q[58:0], x_q[81]} : {r_q[57:0], x_q[81:80]};
	assign trial   = (op_q == DS_DIV) ? {2'b0, den_q} : {q_q[57:0], 2'b01};
	assign ge      = shifted >= trial;
	assign done    = done_q;
	assign quo     = q_q;
	assign ovf     = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			op_q    <= DS_DIV;
			x_q     <= '0;
			r_q     <= '0;
			den_q   <= '0;
			q_q     <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DS_IDLE: begin
					if (cmd.go) begin
						op_q  <= cmd.op;
						den_q <= cmd.den;
						r_q   <= '0;
						q_q   <= '0;
						ovf_q <= 1'b0;
						if (cmd.op == DS_DIV) begin
							x_q   <= cmd.frac24 ? {cmd.num[57:0], 24'b0}
								: {8'b0, cmd.num[57:0], 16'b0};
							cnt_q <= 7'd81;
						end else begin
							x_q   <= {cmd.num, 18'b0};
							cnt_q <= 7'd31;
						end
						state_q <= DS_RUN;
					end
				end
				DS_RUN: begin
					r_q <= ge ? shifted - trial : shifted;
					q_q <= {q_q[62:0], ge};
					if (op_q == DS_DIV) begin
						x_q   <= {x_q[80:0], 1'b0};
						ovf_q <= ovf_q | q_q[63];
					end else begin
						x_q <= {x_q[79:0], 2'b0};
					end
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd0) begin
						done_q  <= 1'b1;
						state_q <= DS_IDLE;
					end
				end
				default: state_q <= DS_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/dis_truth_kinematics.sv
// DIS truth kinematics, electron method.
// Requests are particle records: a request is accepted at a rising edge with start
// high and busy low. A record that is not the last of its event is accepted and
// busy stays low. The last record of an event that holds a beam electron, a beam
// hadron and a scattered electron starts the computation: busy is high while one
// multiplier builds the four Minkowski products (16 terms) and one restoring unit
// forms y, nu and x (82 steps each) and W (32 steps). The result then appears on
// res with res_valid high for exactly one cycle; the receiver cannot stall it. A
// last record of an incomplete event clears the event and yields no result.
// proton_mass is written through the APB port at address 0; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// Reset clears the event state and loads the default proton mass; no result is
// pending after reset. Depends on dtk_pkg, dtk_select, dtk_mac and dtk_divsqrt.
`default_nettype none

module dis_truth_kinematics
	import dtk_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  req_t             req,
	output logic             res_valid,
	output res_t             res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MK_GO,
		ST_MK_WAIT,
		ST_Y_GO,
		ST_Y_WAIT,
		ST_NU_GO,
		ST_NU_WAIT,
		ST_X_GO,
		ST_X_WAIT,
		ST_W_GO,
		ST_W_WAIT
	} st_t;

	st_t         state_q;
	logic [30:0] pm_q;
	res_t        res_q;
	logic        res_valid_q;
	logic        fault_q;
	logic        take, compute, clear, mk_done, ds_done, ds_ovf;
	event_t      ev;
	mk_res_t     mk;
	ds_cmd_t     cmd;
	logic [63:0] ds_quo;
	mk_t         q2, qp, ep, w2;
	logic [57:0] mq2, mqp, mep;

	function automatic logic [47:0] sat48(input logic neg, input logic [63:0] m,
		input logic big);
		logic over;
		over = big || (m > 64'h0000_7FFF_FFFF_FFFF);
		if (!neg) begin
			sat48 = over ? 48'h7FFF_FFFF_FFFF : m[47:0];
		end else if (big || m > 64'h0000_8000_0000_0000) begin
			sat48 = 48'h8000_0000_0000;
		end else begin
			sat48 = 48'(-m[47:0]);
		end
	endfunction

	function automatic logic [31:0] sat32(input logic neg, input logic [63:0] m,
		input logic big);
		logic over;
		over = big || (m > 64'h0000_0000_7FFF_FFFF);
		if (!neg) begin
			sat32 = over ? 32'h7FFF_FFFF : m[31:0];
		end else if (big || m > 64'h0000_0000_8000_0000) begin
			sat32 = 32'h8000_0000;
		end else begin
			sat32 = 32'(-m[31:0]);
		end
	endfunction

	assign take      = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign clear     = (state_q == ST_W_WAIT) && ds_done;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr == 3'd0) ? {1'b0, pm_q} : 32'd0;

	assign q2  = -mk.qq;
	assign qp  = mk.qh;
	assign ep  = mk.eh;
	assign w2  = mk.ss;
	assign mq2 = q2[57] ? 58'(-q2) : 58'(q2);
	assign mqp = qp[57] ? 58'(-qp) : 58'(qp);
	assign mep = ep[57] ? 58'(-ep) : 58'(ep);

	always_comb begin
		cmd.go     = 1'b0;
		cmd.op     = DS_DIV;
		cmd.frac24 = 1'b1;
		cmd.num    = {6'b0, mqp};
		cmd.den    = mep;
		case (state_q)
			ST_Y_GO: begin
				cmd.go = 1'b1;
			end
			ST_NU_GO: begin
				cmd.go     = 1'b1;
				cmd.frac24 = 1'b0;
				cmd.den    = {27'b0, pm_q};
			end
			ST_X_GO: begin
				cmd.go  = 1'b1;
				cmd.num = {6'b0, mq2};
				cmd.den = {mqp[56:0], 1'b0};
			end
			ST_W_GO: begin
				cmd.go  = 1'b1;
				cmd.op  = DS_SQRT;
				cmd.num = {w2[47:0], 16'b0};
			end
			default: begin
				cmd.go = 1'b0;
			end
		endcase
	end

	dtk_select u_select (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.req     (req),
		.clear   (clear),
		.ev      (ev),
		.compute (compute)
	);

	dtk_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (state_q == ST_MK_GO),
		.ev     (ev),
		.done   (mk_done),
		.mk     (mk)
	);

	dtk_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.done   (ds_done),
		.quo    (ds_quo),
		.ovf    (ds_ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q <= PM_RESET;
		end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
			pm_q <= pwdata[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			fault_q     <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (compute) begin
						state_q <= ST_MK_GO;
					end
				end
				ST_MK_GO: begin
					state_q <= ST_MK_WAIT;
				end
				ST_MK_WAIT: begin
					if (mk_done) begin
						state_q <= ST_Y_GO;
					end
				end
				ST_Y_GO: begin
					res_q.q_squared <= sat48(q2[57], {6'b0, mq2}, 1'b0);
					fault_q         <= 1'b0;
					state_q         <= ST_Y_WAIT;
				end
				ST_Y_WAIT: begin
					if (ds_done) begin
						if (ep == '0) begin
							res_q.inelasticity_y <= '0;
							fault_q              <= 1'b1;
						end else begin
							res_q.inelasticity_y <= sat32(qp[57] ^ ep[57], ds_quo, ds_ovf);
						end
						state_q <= ST_NU_GO;
					end
				end
				ST_NU_GO: begin
					state_q <= ST_NU_WAIT;
				end
				ST_NU_WAIT: begin
					if (ds_done) begin
						if (pm_q == '0) begin
							res_q.energy_transfer_nu <= '0;
							fault_q                  <= 1'b1;
						end else begin
							res_q.energy_transfer_nu <= sat48(qp[57], ds_quo, ds_ovf);
						end
						state_q <= ST_X_GO;
					end
				end
				ST_X_GO: begin
					state_q <= ST_X_WAIT;
				end
				ST_X_WAIT: begin
					if (ds_done) begin
						if (qp == '0) begin
							res_q.bjorken_x <= '0;
							fault_q         <= 1'b1;
						end else begin
							res_q.bjorken_x <= sat32(q2[57] ^ qp[57], ds_quo, ds_ovf);
						end
						state_q <= ST_W_GO;
					end
				end
				ST_W_GO: begin
					state_q <= ST_W_WAIT;
				end
				ST_W_WAIT: begin
					if (ds_done) begin
						if (w2[57]) begin
							res_q.invariant_mass_w <= '0;
							res_q.w_invalid        <= 1'b1;
						end else if (w2[56:48] != '0) begin
							res_q.invariant_mass_w <= 32'hFFFF_FFFF;
							res_q.w_invalid        <= 1'b0;
						end else begin
							res_q.invariant_mass_w <= ds_quo[31:0];
							res_q.w_invalid        <= 1'b0;
						end
						res_q.divide_fault <= fault_q;
						res_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !res_valid)
		else $error("Result strobe lasted more than one cycle.");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !busy)
		else $error("Result shown while the block is still busy.");

	a_plain_record: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !req.last_in_event) |=> !busy)
		else $error("A record that is not last made the block busy.");

	a_compute_starts: assert property (@(posedge clk) disable iff (!arst_n)
		compute |=> (state_q == ST_MK_GO))
		else $error("Complete event did not start the computation.");
`endif

endmodule

`default_nettype wire

### tb/tb_dis_truth_kinematics.sv
// Self-checking testbench for dis_truth_kinematics (DIS electron-method kinematics).
// Drives particle records and proton_mass writes, predicts each event's result and
// checks it field by field. Depends on dtk_pkg and the block's RTL.
`default_nettype none

module tb_dis_truth_kinematics;
	import dtk_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          LIMIT_CYCLES = 2_000_000;
	localparam int          DRAIN_CYCLES = 400;
	localparam bit   [63:0] QUOT_CAP     = 64'h4000_0000_0000_0000;
	localparam logic [2:0]  ADDR_PMASS   = 3'd0;

	typedef longint fvec_t[4];
	typedef enum int {ROLE_EBEAM, ROLE_HBEAM, ROLE_SCAT, ROLE_NOISE} role_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        res_valid;
	res_t        res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	req_t   record_q[$];
	res_t   kin_q[$];
	int     errors = 0;
	int     cycles = 0;
	int     gap_left = 0;
	bit     idle_mode = 1'b1;
	bit [30:0] pmass = PM_RESET;
	fvec_t  ev_e, ev_h, ev_s;
	bit     have_e, have_h, have_s;

	dis_truth_kinematics DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.res_valid(res_valid), .res(res), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	function automatic bit [63:0] magn(longint a);
		return (a < 0) ? 64'(-a) : 64'(a);
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		bit [63:0] ma, mb, p;
		ma = magn(a);
		mb = magn(b);
		p = (ma >> 16) * mb + (((ma & 64'hFFFF) * mb) >> 16);
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint mdot(fvec_t a, fvec_t b);
		return fx_mul(a[3], b[3]) - fx_mul(a[0], b[0]) - fx_mul(a[1], b[1])
			- fx_mul(a[2], b[2]);
	endfunction

	function automatic bit [63:0] fx_div(bit [63:0] n, bit [63:0] d, int frac);
		bit [63:0] qi, r, qf;
		qi = n / d;
		r = n % d;
		qf = 0;
		if (qi > (QUOT_CAP >> frac))
			return QUOT_CAP;
		for (int i = 0; i < frac; i++) begin
			r = r << 1;
			qf = qf << 1;
			if (r >= d) begin
				r = r - d;
				qf[0] = 1'b1;
			end
		end
		qi = (qi << frac) | qf;
		return (qi > QUOT_CAP) ? QUOT_CAP : qi;
	endfunction

	function automatic bit [63:0] clamp(bit neg, bit [63:0] m, int w);
		bit [63:0] maxp, mask;
		maxp = (64'd1 << (w - 1)) - 1;
		mask = (64'd1 << w) - 1;
		if (!neg)
			return (m > maxp) ? maxp : m;
		if (m > maxp + 1)
			m = maxp + 1;
		return (64'd0 - m) & mask;
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] n);
		bit [63:0] rt, b;
		rt = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= rt + b) begin
				n = n - (rt + b);
				rt = (rt >> 1) + b;
			end else begin
				rt = rt >> 1;
			end
			b = b >> 2;
		end
		return rt;
	endfunction

	function automatic void clear_event();
		for (int i = 0; i < 4; i++) begin
			ev_e[i] = 0;
			ev_h[i] = 0;
			ev_s[i] = 0;
		end
		have_e = 0;
		have_h = 0;
		have_s = 0;
	endfunction

	function automatic void predict_kinematics(req_t r);
		fvec_t v, q, s;
		longint q2, qp, ep, w2;
		bit [63:0] t;
		bit fault;
		res_t o;
		v[0] = r.mom_x;
		v[1] = r.mom_y;
		v[2] = r.mom_z;
		v[3] = r.energy;
		fault = 0;
		o = '0;
		if (!(have_e && have_h && have_s)) begin
			if (r.gen_status == STATUS_BEAM && r.pdg_code == CODE_ELECTRON) begin
				ev_e = v;
				have_e = 1;
			end else if (r.gen_status == STATUS_BEAM &&
					(r.pdg_code == CODE_PROTON || r.pdg_code == CODE_NEUTRON)) begin
				ev_h = v;
				have_h = 1;
			end else if (r.gen_status == STATUS_FINAL && r.pdg_code == CODE_ELECTRON &&
					!have_s) begin
				ev_s = v;
				have_s = 1;
			end
		end
		if (!r.last_in_event)
			return;
		if (!(have_e && have_h && have_s)) begin
			clear_event();
			return;
		end
		for (int i = 0; i < 4; i++) begin
			q[i] = ev_e[i] - ev_s[i];
			s[i] = ev_h[i] + q[i];
		end
		q2 = -mdot(q, q);
		qp = mdot(q, ev_h);
		ep = mdot(ev_e, ev_h);
		w2 = mdot(s, s);
		t = clamp(q2 < 0, magn(q2), 48);
		o.q_squared = t[47:0];
		if (ep == 0) begin
			fault = 1;
		end else begin
			t = clamp((qp < 0) != (ep < 0), fx_div(magn(qp), magn(ep), 24), 32);
			o.inelasticity_y = t[31:0];
		end
		if (pmass == 0) begin
			fault = 1;
		end else begin
			t = clamp(qp < 0, fx_div(magn(qp), 64'(pmass), 16), 48);
			o.energy_transfer_nu = t[47:0];
		end
		if (qp == 0) begin
			fault = 1;
		end else begin
			t = clamp((q2 < 0) != (qp < 0), fx_div(magn(q2), magn(qp) << 1, 24), 32);
			o.bjorken_x = t[31:0];
		end
		if (w2 < 0) begin
			o.w_invalid = 1;
		end else if (64'(w2) >= (64'd1 << 48)) begin
			o.invariant_mass_w = 32'hFFFF_FFFF;
		end else begin
			t = int_sqrt(64'(w2) << 16);
			o.invariant_mass_w = t[31:0];
		end
		o.divide_fault = fault;
		kin_q.push_back(o);
		clear_event();
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				predict_kinematics(req);
			if (start && busy) begin
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (record_q.size() > 0) begin
				req <= record_q.pop_front();
				start <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					idle_mode = !idle_mode;
				gap_left = idle_mode ? $urandom_range(0, 3) : 0;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid) begin
			if (kin_q.size() == 0) begin
				$error("unexpected result %p", res);
				errors++;
			end else begin
				res_t e;
				e = kin_q.pop_front();
				if (res.q_squared !== e.q_squared) begin
					$error("q_squared exp %0d got %0d", e.q_squared, res.q_squared);
					errors++;
				end
				if (res.inelasticity_y !== e.inelasticity_y) begin
					$error("inelasticity_y exp %0d got %0d", e.inelasticity_y,
						res.inelasticity_y);
					errors++;
				end
				if (res.energy_transfer_nu !== e.energy_transfer_nu) begin
					$error("energy_transfer_nu exp %0d got %0d", e.energy_transfer_nu,
						res.energy_transfer_nu);
					errors++;
				end
				if (res.bjorken_x !== e.bjorken_x) begin
					$error("bjorken_x exp %0d got %0d", e.bjorken_x, res.bjorken_x);
					errors++;
				end
				if (res.invariant_mass_w !== e.invariant_mass_w) begin
					$error("invariant_mass_w exp %0d got %0d", e.invariant_mass_w,
						res.invariant_mass_w);
					errors++;
				end
				if (res.w_invalid !== e.w_invalid) begin
					$error("w_invalid exp %0d got %0d", e.w_invalid, res.w_invalid);
					errors++;
				end
				if (res.divide_fault !== e.divide_fault) begin
					$error("divide_fault exp %0d got %0d", e.divide_fault, res.divide_fault);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [31:0] pick_comp(int kind);
		case (kind)
			0: return 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
			1: return $urandom;
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'h0000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h8000_0000;
					3: return 32'hFFFF_FFFF;
					default: return 32'h0001_0000;
				endcase
			end
		endcase
	endfunction

	function automatic void add_record(logic [7:0] st, logic [31:0] code, int kind, bit last);
		req_t r;
		r.gen_status = st;
		r.pdg_code = code;
		r.mom_x = pick_comp(kind);
		r.mom_y = pick_comp(kind);
		r.mom_z = pick_comp(kind);
		r.energy = pick_comp(kind);
		r.last_in_event = last;
		record_q.push_back(r);
	endfunction

	function automatic void add_vec(logic [7:0] st, logic [31:0] code, logic [31:0] x,
			logic [31:0] y, logic [31:0] z, logic [31:0] en, bit last);
		req_t r;
		r = '{st, code, x, y, z, en, last};
		record_q.push_back(r);
	endfunction

	function automatic void add_event(bit complete, int kind);
		role_t roles[$];
		role_t tmp;
		int j, drop, n;
		roles = '{ROLE_EBEAM, ROLE_HBEAM, ROLE_SCAT};
		if (!complete) begin
			drop = $urandom_range(0, 2);
			roles.delete(drop);
		end
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++)
			roles.push_back(role_t'($urandom_range(0, 3)));
		for (int i = roles.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = roles[i];
			roles[i] = roles[j];
			roles[j] = tmp;
		end
		if (!complete)
			foreach (roles[i])
				if (i >= 2 && roles[i] != ROLE_NOISE)
					roles[i] = ROLE_NOISE;
		foreach (roles[i]) begin
			bit last;
			last = (i == roles.size() - 1);
			case (roles[i])
				ROLE_EBEAM: add_record(STATUS_BEAM, CODE_ELECTRON, kind, last);
				ROLE_HBEAM: add_record(STATUS_BEAM,
					$urandom_range(0, 1) ? CODE_PROTON : CODE_NEUTRON, kind, last);
				ROLE_SCAT:  add_record(STATUS_FINAL, CODE_ELECTRON, kind, last);
				default:    add_record(8'($urandom), $urandom, 1, last);
			endcase
		end
	endfunction

	task automatic wait_idle();
		do @(posedge clk);
		while (record_q.size() != 0 || start || busy || kin_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_pmass(logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_PMASS;
		pwdata <= v;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		pmass = v[30:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_phase(int count);
		int r;
		while (record_q.size() < count) begin
			r = $urandom_range(0, 19);
			if (r < 13)
				add_event(1, 0);
			else if (r < 15)
				add_event(1, ($urandom_range(0, 1) ? 1 : 2));
			else if (r < 17)
				add_event(0, 0);
			else
				add_record(8'($urandom), $urandom, 1, $urandom_range(0, 1));
		end
	endtask

	initial begin
		logic [31:0] pm_values[5];
		pm_values = '{32'd1, 32'h7FFF_FFFF, 32'd65536, 32'd0, 32'd0};
		pm_values[3] = $urandom_range(1, 32'h7FFF_FFFF);
		clear_event();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_vec(STATUS_BEAM, CODE_ELECTRON, 0, 0, 32'hFFF6_0000, 32'h000A_0000, 0);
		add_vec(STATUS_BEAM, CODE_PROTON, 0, 0, 32'h0064_0000, 32'h0064_0000, 0);
		add_vec(8'd22, 32'sd22, $urandom, $urandom, $urandom, $urandom, 0);
		add_vec(STATUS_FINAL, CODE_ELECTRON, 32'h0002_0000, 0, 32'hFFF8_0000,
			32'h0008_4000, 0);
		add_vec(STATUS_FINAL, CODE_ELECTRON, 32'h7FFF_FFFF, 0, 0, 0, 1);
		add_vec(STATUS_BEAM, CODE_NEUTRON, 0, 0, 0, 0, 0);
		add_vec(STATUS_BEAM, CODE_ELECTRON, 0, 0, 0, 0, 0);
		add_vec(STATUS_FINAL, CODE_ELECTRON, 0, 0, 0, 0, 1);
		add_vec(STATUS_BEAM, CODE_ELECTRON, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 0);
		add_vec(STATUS_BEAM, CODE_PROTON, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 0);
		add_vec(STATUS_FINAL, CODE_ELECTRON, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 1);
		add_vec(STATUS_BEAM, CODE_ELECTRON, 0, 0, 0, 32'h0001_0000, 0);
		add_vec(STATUS_BEAM, CODE_PROTON, 32'h0100_0000, 0, 0, 0, 0);
		add_vec(STATUS_FINAL, CODE_ELECTRON, 0, 0, 0, 32'h7FFF_FFFF, 1);
		add_vec(STATUS_BEAM, CODE_ELECTRON, 0, 0, 0, 32'h7FFF_FFFF, 0);
		add_vec(STATUS_FINAL, CODE_ELECTRON, 0, 0, 0, 32'h8000_0000, 1);
		add_vec(STATUS_BEAM, CODE_PROTON, 0, 0, 0, 32'h7FFF_FFFF, 0);
		add_vec(STATUS_BEAM, CODE_ELECTRON, 0, 0, 0, 32'h7FFF_FFFF, 0);
		add_vec(STATUS_FINAL, CODE_ELECTRON, 0, 0, 0, 32'h8000_0000, 1);
		add_vec(8'hFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1);

		random_phase(110);
		foreach (pm_values[i]) begin
			wait_idle();
			write_pmass(pm_values[i]);
			random_phase(100);
		end
		wait_idle();

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
design/dtk_pkg.sv
design/dtk_select.sv
design/dtk_mac.sv
design/dtk_divsqrt.sv
design/dis_truth_kinematics.sv
tb/tb_dis_truth_kinematics.sv
